// File: design/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the byte-serial UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int ByteW  = 8;
    localparam int PointW = 21;
    localparam int CountW = 2;

    localparam logic [PointW-1:0] SubstChar = 21'h00003F;

    // Pending continuation counts loaded by each lead byte form
    localparam logic [CountW-1:0] CntNone  = 2'd0;
    localparam logic [CountW-1:0] CntTwo   = 2'd1;
    localparam logic [CountW-1:0] CntThree = 2'd2;
    localparam logic [CountW-1:0] CntFour  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [PointW-1:0] code_point;
        logic              bad_lead;
    } result_t;

endpackage

// File: design/utf8d_in_stage.sv
// ----------------------------------------------------------------------------
// utf8d_in_stage
// Input register for one byte; hands it on when the decode stage advances.
// ----------------------------------------------------------------------------
module utf8d_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [utf8d_pkg::ByteW-1:0] in_byte,
    input  logic                        out_hold,
    output logic                        advance,
    output logic [utf8d_pkg::ByteW-1:0] byte_q
);

    logic                        vld_reg;
    logic                        vld_next;
    logic [utf8d_pkg::ByteW-1:0] byte_reg;
    logic                        accept;

    assign advance  = vld_reg && !out_hold;
    assign in_stall = vld_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign byte_q   = byte_reg;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

// File: design/utf8d_core.sv
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and decode logic: lead classification, payload assembly.
// ----------------------------------------------------------------------------
module utf8d_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [utf8d_pkg::ByteW-1:0] byte_q,
    output utf8d_pkg::result_t          res
);

    logic [utf8d_pkg::CountW-1:0] pending_count_reg;
    logic [utf8d_pkg::CountW-1:0] pending_count_next;
    logic [utf8d_pkg::PointW-1:0] partial_point_reg;
    logic [utf8d_pkg::PointW-1:0] partial_point_next;
    logic [utf8d_pkg::PointW-1:0] shifted;

    // continuation bytes are not checked, only the low six bits count
    assign shifted = {partial_point_reg[utf8d_pkg::PointW-7:0], byte_q[5:0]};

    always_comb
    begin
        pending_count_next = pending_count_reg;
        partial_point_next = partial_point_reg;
        res.valid          = 1'b0;
        res.code_point     = shifted;
        res.bad_lead       = 1'b0;
        if (pending_count_reg != utf8d_pkg::CntNone)
        begin
            partial_point_next = shifted;
            pending_count_next = pending_count_reg - 2'd1;
            res.valid          = (pending_count_reg == utf8d_pkg::CntTwo);
        end
        else if (!byte_q[7])
        begin
            res.valid      = 1'b1;
            res.code_point = {13'd0, byte_q};
        end
        else if (byte_q[7:5] == 3'b110)
        begin
            partial_point_next = {16'd0, byte_q[4:0]};
            pending_count_next = utf8d_pkg::CntTwo;
        end
        else if (byte_q[7:4] == 4'b1110)
        begin
            partial_point_next = {17'd0, byte_q[3:0]};
            pending_count_next = utf8d_pkg::CntThree;
        end
        else if (byte_q[7:3] == 5'b11110)
        begin
            partial_point_next = {18'd0, byte_q[2:0]};
            pending_count_next = utf8d_pkg::CntFour;
        end
        else
        begin
            res.valid      = 1'b1;
            res.code_point = utf8d_pkg::SubstChar;
            res.bad_lead   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_count_reg <= utf8d_pkg::CntNone;
            partial_point_reg <= '0;
        end
        else if (advance)
        begin
            pending_count_reg <= pending_count_next;
            partial_point_reg <= partial_point_next;
        end
    end

    // a byte inside a sequence always counts the sequence down by one
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (pending_count_reg != utf8d_pkg::CntNone)
        |=> pending_count_reg == $past(pending_count_reg) - 2'd1)
        else $error("pending count did not step down");

    // an invalid lead leaves the sequence state alone
    a_bad_lead_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.bad_lead
        |=> (pending_count_reg == utf8d_pkg::CntNone) && $stable(partial_point_reg))
        else $error("invalid lead changed sequence state");

    // a bad lead is only flagged when no sequence is open
    a_bad_lead_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.bad_lead |-> pending_count_reg == utf8d_pkg::CntNone)
        else $error("bad lead flagged inside a sequence");

endmodule

// File: design/utf8d_out_stage.sv
// ----------------------------------------------------------------------------
// utf8d_out_stage
// Result register holding one decoded code point until it is taken.
// ----------------------------------------------------------------------------
module utf8d_out_stage
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  utf8d_pkg::result_t           res,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         out_hold,
    output logic [utf8d_pkg::PointW-1:0] code_point,
    output logic                         bad_lead
);

    logic                         vld_reg;
    logic                         vld_next;
    logic [utf8d_pkg::PointW-1:0] point_reg;
    logic                         bad_reg;
    logic                         load;

    assign load       = advance && res.valid;
    assign out_hold   = vld_reg && out_stall;
    assign out_valid  = vld_reg;
    assign code_point = point_reg;
    assign bad_lead   = bad_reg;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            point_reg <= res.code_point;
            bad_reg   <= res.bad_lead;
        end
    end

endmodule

// File: design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top: byte-serial UTF-8 decoder
// Path: input register, combinational decode, then the output (result) register.
// Throughput: one byte per cycle unless a held result stalls the input stage.
// Reset: async, active low; clears valids and the pending sequence state.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [utf8d_pkg::ByteW-1:0]  in_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [utf8d_pkg::PointW-1:0] code_point,
    output logic                         bad_lead
);

    logic                        advance;
    logic                        out_hold;
    logic [utf8d_pkg::ByteW-1:0] byte_q;
    utf8d_pkg::result_t          res;

    utf8d_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .out_hold (out_hold),
        .advance  (advance),
        .byte_q   (byte_q)
    );

    utf8d_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_q  (byte_q),
        .res     (res)
    );

    utf8d_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .res        (res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_hold   (out_hold),
        .code_point (code_point),
        .bad_lead   (bad_lead)
    );

    // flagged words always carry the substitute
    a_subst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_lead |-> code_point == utf8d_pkg::SubstChar)
        else $error("bad lead without substitute");

    // a word that is being decoded into a free result slot never backs up input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

endmodule
